>>> sv/wav_pcm_to_int16_converter_top_macros.svh
// Assertion macros shared by the converter modules.
`ifndef WAV_PCM_TO_INT16_CONVERTER_TOP_MACROS_SVH
`define WAV_PCM_TO_INT16_CONVERTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define WPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define WPC_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WPC_ASSERT(lbl, clk, rst, prop, msg)
`define WPC_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> sv/wpc_pkg.sv
package wpc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_SAMPLE = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_FORMAT    = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT    = 2'd2;

   localparam int unsigned MAX_CHANNELS = 8;
   localparam int unsigned QUEUE_DEPTH  = 2;

   // sample width codes
   localparam logic [2:0] NB_ONE   = 3'd1;
   localparam logic [2:0] NB_TWO   = 3'd2;
   localparam logic [2:0] NB_THREE = 3'd3;
   localparam logic [2:0] NB_FOUR  = 3'd4;

   // one gathered sample word on its way to conversion
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        is_float;
      logic [2:0]  channel;
      logic        last;
   } entry_type;

endpackage

>>> sv/wpc_queue.sv
module wpc_queue
   import wpc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      enq,
   input  entry_type enq_data,
   output logic      full,
   input  logic      deq,
   output logic      empty,
   output entry_type head
);
`include "wav_pcm_to_int16_converter_top_macros.svh"

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_enq, do_deq;

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = slot_ff[rd_ptr_ff];
   assign do_enq = enq && !full;
   assign do_deq = deq && !empty;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (!do_enq && do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold stored words
   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ptr_ff] <= enq_data;
      end
   end

   `WPC_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CW'(DEPTH), "queue overfilled")
   `WPC_ASSERT(a_count_up, clock, reset, (do_enq && !do_deq) |=> (count_ff == $past(count_ff) + 1'b1), "queue count missed a word")
   `WPC_ASSERT(a_count_down, clock, reset, (!do_enq && do_deq) |=> (count_ff == $past(count_ff) - 1'b1), "queue count missed a removal")

endmodule

>>> sv/wpc_front.sv
module wpc_front
   import wpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  logic [7:0] data_byte,
   input  logic      first_byte,
   input  logic      last_byte,
   input  logic [2:0] bytes_per_sample,
   input  logic      sample_format,
   input  logic [3:0] channel_count,
   output logic      enq,
   output entry_type enq_data
);
`include "wav_pcm_to_int16_converter_top_macros.svh"

   logic [23:0] gather_ff, gather_in;
   logic [1:0]  index_ff, index_in;
   logic [2:0]  chan_ff, chan_in;

   logic [2:0]  nbytes;
   logic [3:0]  nch;
   logic [23:0] g_eff;
   logic [1:0]  i_eff;
   logic [2:0]  c_eff;
   logic [31:0] word;
   logic        complete;
   logic [3:0]  chan_inc;

   // clamp configuration to legal ranges
   always_comb begin
      if (bytes_per_sample == 3'd0) begin
         nbytes = NB_ONE;
      end else if (bytes_per_sample > NB_FOUR) begin
         nbytes = NB_FOUR;
      end else begin
         nbytes = bytes_per_sample;
      end
      if (channel_count == 4'd0) begin
         nch = 4'd1;
      end else if (channel_count > 4'(MAX_CHANNELS)) begin
         nch = 4'(MAX_CHANNELS);
      end else begin
         nch = channel_count;
      end
   end

   // gather the byte and decide whether a sample completes
   always_comb begin
      g_eff    = first_byte ? '0 : gather_ff;
      i_eff    = first_byte ? '0 : index_ff;
      c_eff    = first_byte ? '0 : chan_ff;
      word     = {8'd0, g_eff} | ({24'd0, data_byte} << {i_eff, 3'b000});
      complete = ({1'b0, i_eff} + 3'd1) >= nbytes;
      chan_inc = {1'b0, c_eff} + 4'd1;

      gather_in = gather_ff;
      index_in  = index_ff;
      chan_in   = chan_ff;
      if (take) begin
         if (complete) begin
            gather_in = '0;
            index_in  = '0;
            chan_in   = (chan_inc >= nch) ? '0 : chan_inc[2:0];
         end else begin
            gather_in = word[23:0];
            index_in  = i_eff + 2'd1;
            chan_in   = c_eff;
         end
         if (last_byte) begin
            gather_in = '0;
            index_in  = '0;
            chan_in   = '0;
         end
      end

      enq               = take && complete;
      enq_data.word     = word;
      enq_data.nbytes   = nbytes;
      enq_data.is_float = sample_format;
      enq_data.channel  = c_eff;
      enq_data.last     = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gather_ff <= '0;
         index_ff  <= '0;
         chan_ff   <= '0;
      end else begin
         gather_ff <= gather_in;
         index_ff  <= index_in;
         chan_ff   <= chan_in;
      end
   end

   `WPC_ASSERT(a_last_clears, clock, reset, (take && last_byte) |=> (index_ff == '0 && chan_ff == '0 && gather_ff == '0), "buffer end did not clear counters")
   `WPC_ASSERT_NEVER(a_index_range, clock, reset, ({1'b0, index_ff} >= NB_FOUR), "byte index out of range")
   `WPC_ASSERT(a_chan_range, clock, reset, (take && !last_byte) |=> ({1'b0, chan_ff} < 4'(MAX_CHANNELS)), "channel index out of range")

endmodule

>>> sv/wpc_back.sv
module wpc_back
   import wpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  entry_type    in_data,
   output logic         in_ready,
   output logic         out_valid,
   output logic signed [15:0] out_sample,
   output logic [2:0]   out_channel,
   output logic         out_last,
   input  logic         out_pop
);
`include "wav_pcm_to_int16_converter_top_macros.svh"

   // stage 1: integer result and float product
   logic        s1_v_ff, s1_v_in;
   logic [15:0] s1_int_ff, s1_int_in;
   logic        s1_flt_ff, s1_flt_in;
   logic        s1_sign_ff, s1_nan_ff, s1_nan_in;
   logic [7:0]  s1_exp_ff;
   logic [38:0] s1_prod_ff, s1_prod_in;
   logic [2:0]  s1_ch_ff;
   logic        s1_last_ff;
   // stage 2: rounded product
   logic        s2_v_ff, s2_v_in;
   logic [15:0] s2_int_ff;
   logic        s2_flt_ff, s2_sign_ff, s2_nan_ff;
   logic [7:0]  s2_exp_ff;
   logic [39:0] s2_rnd_ff, s2_rnd_in;
   logic [2:0]  s2_ch_ff;
   logic        s2_last_ff;
   // stage 3: output register
   logic        s3_v_ff, s3_v_in;
   logic [15:0] s3_smp_ff, s3_smp_in;
   logic [2:0]  s3_ch_ff;
   logic        s3_last_ff;

   logic        s1_ready, s2_ready, s3_ready;
   logic        s1_go, s2_go, s3_go;

   assign s3_ready = !s3_v_ff || out_pop;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_go    = in_valid && s1_ready;
   assign s2_go    = s1_v_ff && s2_ready;
   assign s3_go    = s2_v_ff && s3_ready;

   // integer conversion and mantissa product
   always_comb begin
      case (in_data.nbytes)
         NB_ONE:   s1_int_in = {in_data.word[7:0] ^ 8'h80, 8'h00};
         NB_TWO:   s1_int_in = in_data.word[15:0];
         NB_THREE: s1_int_in = in_data.word[23:8];
         default:  s1_int_in = in_data.word[31:16];
      endcase
      s1_flt_in  = (in_data.nbytes == NB_FOUR) && in_data.is_float;
      s1_nan_in  = (in_data.word[30:23] == 8'hFF) && (in_data.word[22:0] != '0);
      s1_prod_in = 39'({1'b1, in_data.word[22:0]}) * 39'd32767;
   end

   // round the product to 24 significant bits, nearest even
   logic [23:0] r_trunc;
   logic        r_up;
   logic [24:0] r_sum;
   always_comb begin
      if (s1_prod_ff[38]) begin
         r_trunc = s1_prod_ff[38:15];
         r_up    = (s1_prod_ff[14:0] > 15'h4000) ||
                   ((s1_prod_ff[14:0] == 15'h4000) && r_trunc[0]);
      end else begin
         r_trunc = s1_prod_ff[37:14];
         r_up    = (s1_prod_ff[13:0] > 14'h2000) ||
                   ((s1_prod_ff[13:0] == 14'h2000) && r_trunc[0]);
      end
      r_sum = {1'b0, r_trunc} + {24'd0, r_up};
      s2_rnd_in = s1_prod_ff[38] ? {r_sum, 15'd0} : {1'b0, r_sum, 14'd0};
   end

   // pass integers through; scale, truncate toward zero and saturate floats
   logic [7:0]  shift_amt;
   logic [39:0] mag;
   logic        big;
   always_comb begin
      shift_amt = 8'd150 - s2_exp_ff;
      big  = (s2_exp_ff >= 8'd150);
      mag  = (shift_amt >= 8'd40) ? '0 : (s2_rnd_ff >> shift_amt[5:0]);
      if (!s2_flt_ff) begin
         s3_smp_in = s2_int_ff;
      end else if (s2_nan_ff || s2_exp_ff == 8'd0) begin
         s3_smp_in = '0;
      end else if (!s2_sign_ff) begin
         s3_smp_in = (big || mag >= 40'd32767) ? 16'h7FFF : mag[15:0];
      end else begin
         s3_smp_in = (big || mag >= 40'd32768) ? 16'h8000 : (16'd0 - mag[15:0]);
      end
   end

   // advance the valid bits
   always_comb begin
      s1_v_in = s1_go ? 1'b1 : (s2_go ? 1'b0 : s1_v_ff);
      s2_v_in = s2_go ? 1'b1 : (s3_go ? 1'b0 : s2_v_ff);
      s3_v_in = s3_go ? 1'b1 : (out_pop ? 1'b0 : s3_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_int_ff  <= s1_int_in;
         s1_flt_ff  <= s1_flt_in;
         s1_sign_ff <= in_data.word[31];
         s1_nan_ff  <= s1_nan_in;
         s1_exp_ff  <= in_data.word[30:23];
         s1_prod_ff <= s1_prod_in;
         s1_ch_ff   <= in_data.channel;
         s1_last_ff <= in_data.last;
      end
      if (s2_go) begin
         s2_int_ff  <= s1_int_ff;
         s2_flt_ff  <= s1_flt_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_rnd_ff  <= s2_rnd_in;
         s2_ch_ff   <= s1_ch_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (s3_go) begin
         s3_smp_ff  <= s3_smp_in;
         s3_ch_ff   <= s2_ch_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   assign out_valid   = s3_v_ff;
   assign out_sample  = s3_smp_ff;
   assign out_channel = s3_ch_ff;
   assign out_last    = s3_last_ff;

   `WPC_ASSERT(a_s2_hold, clock, reset, (s2_v_ff && !s3_ready) |=> s2_v_ff, "stage 2 word lost while stalled")
   `WPC_ASSERT(a_s1_hold, clock, reset, (s1_v_ff && !s2_ready) |=> s1_v_ff, "stage 1 word lost while stalled")
   `WPC_ASSERT(a_s1_move, clock, reset, s2_go |=> s2_v_ff, "stage 2 did not take its word")

endmodule

>>> sv/wav_pcm_to_int16_converter_top.sv
// WAV PCM to int16 converter. Takes one data-chunk byte per clock while full
// is low (push/full) and returns one signed 16-bit sample with its channel
// number per completed sample (empty/pop). After its last byte is taken, a
// sample is written into the front queue and then carried through the
// conversion pipeline (mantissa multiply, round, scale and saturate) to the
// result side. Bytes are taken every clock as long as results are popped;
// full rises only when the two-word queue and the pipeline are all backed
// up. Registers: 0 bytes per sample, 1 sample format (float used only at
// four bytes), 2 channel count; write them only while no sample is in flight.
module wav_pcm_to_int16_converter_top
   import wpc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first_byte,
   input  logic              req_last_byte,
   output logic              empty,
   input  logic              pop,
   output logic signed [15:0] rsp_sample,
   output logic [2:0]        rsp_channel,
   output logic              rsp_last_sample,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_wdata
);

   logic [2:0] bps_ff;
   logic       fmt_ff;
   logic [3:0] nch_ff;

   logic       take, enq, q_full, q_empty, deq, out_valid;
   entry_type  enq_data, head;

   assign csr_ready = 1'b1;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= NB_TWO;
         fmt_ff <= 1'b0;
         nch_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYTES_PER_SAMPLE: bps_ff <= csr_wdata[2:0];
            CSR_SAMPLE_FORMAT:    fmt_ff <= csr_wdata[0];
            CSR_CHANNEL_COUNT:    nch_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign full = q_full;
   assign take = push && !q_full;

   wpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .data_byte        (req_data_byte),
      .first_byte       (req_first_byte),
      .last_byte        (req_last_byte),
      .bytes_per_sample (bps_ff),
      .sample_format    (fmt_ff),
      .channel_count    (nch_ff),
      .enq              (enq),
      .enq_data         (enq_data)
   );

   wpc_queue #(.DEPTH(DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_data (enq_data),
      .full     (q_full),
      .deq      (deq),
      .empty    (q_empty),
      .head     (head)
   );

   logic in_ready;
   assign deq = in_ready && !q_empty;

   wpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_data     (head),
      .in_ready    (in_ready),
      .out_valid   (out_valid),
      .out_sample  (rsp_sample),
      .out_channel (rsp_channel),
      .out_last    (rsp_last_sample),
      .out_pop     (pop)
   );

   assign empty = !out_valid;

endmodule
